// ===== rtl/core/bgf_pkg.sv =====
// ----------------------------------------------------------------------------
// bgf_pkg
// shared types and constants of the button gesture state machine
// ----------------------------------------------------------------------------
`default_nettype none

package bgf_pkg;

    localparam int unsigned TimerW    = 16;
    localparam int unsigned CfgIndexW = 2;
    localparam int unsigned InDataW   = 8;
    localparam int unsigned OutDataW  = 32;

    localparam logic [TimerW-1:0] DebounceTimeRst     = 16'd20;
    localparam logic [TimerW-1:0] LongPressTimeRst    = 16'd1000;
    localparam logic [TimerW-1:0] SelfTestArmTimeRst  = 16'd5000;

    localparam logic [CfgIndexW-1:0] CfgDebounceTime    = 2'd0;
    localparam logic [CfgIndexW-1:0] CfgLongPressTime   = 2'd1;
    localparam logic [CfgIndexW-1:0] CfgSelfTestArmTime = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_DEBOUNCE  = 3'd1,
        ST_PRESSED   = 3'd2,
        ST_CLICK     = 3'd3,
        ST_WAIT_LONG = 3'd4,
        ST_ARMED     = 3'd5,
        ST_CONFIRM   = 3'd6,
        ST_SELF_TEST = 3'd7
    } state_t;

    typedef enum logic [2:0] {
        EV_PRESSED  = 3'd0,
        EV_RELEASED = 3'd1,
        EV_DEB_OK   = 3'd2,
        EV_LONG     = 3'd3,
        EV_TIMEOUT  = 3'd4,
        EV_ACCEPTED = 3'd5,
        EV_OTHER    = 3'd6
    } event_t;

    typedef enum logic [1:0] {
        FX_NONE    = 2'd0,
        FX_START   = 2'd1,
        FX_CANCEL  = 2'd2,
        FX_PUBLISH = 2'd3
    } effect_t;

    typedef struct packed {
        logic [TimerW-1:0] debounce_time;
        logic [TimerW-1:0] long_press_time;
        logic [TimerW-1:0] self_test_arm_time;
    } timers_t;

    // packed lowest field last so the struct maps onto tdata directly
    typedef struct packed {
        logic [TimerW-1:0] timer_value;
        effect_t           effect_code;
        state_t            new_state;
        state_t            prior_state;
        logic              applied;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/bgf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bgf_cfg_regs
// timer duration registers written through the configuration channel
// ----------------------------------------------------------------------------
`default_nettype none

module bgf_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic [bgf_pkg::CfgIndexW-1:0]   wr_index,
    input  wire logic [bgf_pkg::TimerW-1:0]      wr_data,
    output bgf_pkg::timers_t                     timers
);

    bgf_pkg::timers_t timers_reg;
    bgf_pkg::timers_t timers_next;

    always_comb
    begin
        timers_next = timers_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                bgf_pkg::CfgDebounceTime:    timers_next.debounce_time      = wr_data;
                bgf_pkg::CfgLongPressTime:   timers_next.long_press_time    = wr_data;
                bgf_pkg::CfgSelfTestArmTime: timers_next.self_test_arm_time = wr_data;
                default:                     timers_next = timers_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timers_reg.debounce_time      <= bgf_pkg::DebounceTimeRst;
            timers_reg.long_press_time    <= bgf_pkg::LongPressTimeRst;
            timers_reg.self_test_arm_time <= bgf_pkg::SelfTestArmTimeRst;
        end
        else
        begin
            timers_reg <= timers_next;
        end
    end

    assign timers = timers_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bgf_fsm.sv =====
// ----------------------------------------------------------------------------
// bgf_fsm
// gesture state register and per-event transition decode
// ----------------------------------------------------------------------------
`default_nettype none

module bgf_fsm (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [2:0]       event_kind,
    input  wire bgf_pkg::timers_t timers,
    output bgf_pkg::result_t      result
);

    bgf_pkg::state_t  state_reg;
    bgf_pkg::state_t  state_next;
    bgf_pkg::event_t  ev;
    logic             hit;
    bgf_pkg::effect_t effect;
    logic [bgf_pkg::TimerW-1:0] timer_value;

    assign ev = bgf_pkg::event_t'(event_kind);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bgf_pkg::ST_IDLE:
            begin
                if (ev == bgf_pkg::EV_PRESSED)
                    state_next = bgf_pkg::ST_DEBOUNCE;
            end
            bgf_pkg::ST_DEBOUNCE:
            begin
                case (ev)
                    bgf_pkg::EV_RELEASED: state_next = bgf_pkg::ST_IDLE;
                    bgf_pkg::EV_DEB_OK:   state_next = bgf_pkg::ST_PRESSED;
                    default:              state_next = state_reg;
                endcase
            end
            bgf_pkg::ST_PRESSED:
            begin
                case (ev)
                    bgf_pkg::EV_RELEASED: state_next = bgf_pkg::ST_CLICK;
                    bgf_pkg::EV_LONG:     state_next = bgf_pkg::ST_WAIT_LONG;
                    default:              state_next = state_reg;
                endcase
            end
            bgf_pkg::ST_WAIT_LONG:
            begin
                if (ev == bgf_pkg::EV_RELEASED)
                    state_next = bgf_pkg::ST_ARMED;
            end
            bgf_pkg::ST_ARMED:
            begin
                case (ev)
                    bgf_pkg::EV_PRESSED: state_next = bgf_pkg::ST_CONFIRM;
                    bgf_pkg::EV_TIMEOUT: state_next = bgf_pkg::ST_IDLE;
                    default:             state_next = state_reg;
                endcase
            end
            bgf_pkg::ST_CONFIRM:
            begin
                case (ev)
                    bgf_pkg::EV_RELEASED: state_next = bgf_pkg::ST_SELF_TEST;
                    bgf_pkg::EV_LONG:     state_next = bgf_pkg::ST_IDLE;
                    default:              state_next = state_reg;
                endcase
            end
            bgf_pkg::ST_CLICK, bgf_pkg::ST_SELF_TEST:
            begin
                if (ev == bgf_pkg::EV_ACCEPTED)
                    state_next = bgf_pkg::ST_IDLE;
            end
            default: state_next = state_reg;
        endcase
    end

    // outputs
    always_comb
    begin
        hit         = 1'b0;
        effect      = bgf_pkg::FX_NONE;
        timer_value = '0;
        unique case (state_reg)
            bgf_pkg::ST_IDLE:
            begin
                if (ev == bgf_pkg::EV_PRESSED)
                begin
                    hit         = 1'b1;
                    effect      = bgf_pkg::FX_START;
                    timer_value = timers.debounce_time;
                end
            end
            bgf_pkg::ST_DEBOUNCE:
            begin
                case (ev)
                    bgf_pkg::EV_RELEASED:
                    begin
                        hit    = 1'b1;
                        effect = bgf_pkg::FX_CANCEL;
                    end
                    bgf_pkg::EV_DEB_OK:
                    begin
                        hit         = 1'b1;
                        effect      = bgf_pkg::FX_START;
                        timer_value = timers.long_press_time;
                    end
                    default: hit = 1'b0;
                endcase
            end
            bgf_pkg::ST_PRESSED:
            begin
                case (ev)
                    bgf_pkg::EV_RELEASED:
                    begin
                        hit    = 1'b1;
                        effect = bgf_pkg::FX_PUBLISH;
                    end
                    bgf_pkg::EV_LONG: hit = 1'b1;
                    default:          hit = 1'b0;
                endcase
            end
            bgf_pkg::ST_WAIT_LONG:
            begin
                if (ev == bgf_pkg::EV_RELEASED)
                begin
                    hit         = 1'b1;
                    effect      = bgf_pkg::FX_START;
                    timer_value = timers.self_test_arm_time;
                end
            end
            bgf_pkg::ST_ARMED:
            begin
                case (ev)
                    bgf_pkg::EV_PRESSED:
                    begin
                        hit    = 1'b1;
                        effect = bgf_pkg::FX_CANCEL;
                    end
                    bgf_pkg::EV_TIMEOUT: hit = 1'b1;
                    default:             hit = 1'b0;
                endcase
            end
            bgf_pkg::ST_CONFIRM:
            begin
                if (ev == bgf_pkg::EV_RELEASED || ev == bgf_pkg::EV_LONG)
                begin
                    hit    = 1'b1;
                    effect = bgf_pkg::FX_PUBLISH;
                end
            end
            bgf_pkg::ST_CLICK, bgf_pkg::ST_SELF_TEST:
            begin
                if (ev == bgf_pkg::EV_ACCEPTED)
                    hit = 1'b1;
            end
            default: hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bgf_pkg::ST_IDLE;
        else if (step)
            state_reg <= state_next;
    end

    assign result.applied     = hit;
    assign result.prior_state = state_reg;
    assign result.new_state   = state_next;
    assign result.effect_code = effect;
    assign result.timer_value = timer_value;

endmodule

`default_nettype wire

// ===== rtl/core/bgf_out_buf.sv =====
// ----------------------------------------------------------------------------
// bgf_out_buf
// two-entry result buffer: output register plus skid slot
// ----------------------------------------------------------------------------
`default_nettype none

module bgf_out_buf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire bgf_pkg::result_t push_data,
    output logic                  can_push,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output bgf_pkg::result_t      out_data
);

    logic             head_valid_reg;
    logic             head_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    bgf_pkg::result_t head_reg;
    bgf_pkg::result_t head_next;
    bgf_pkg::result_t skid_reg;
    bgf_pkg::result_t skid_next;
    logic             pop;

    assign pop = head_valid_reg && out_ready;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        case ({push, pop})
            2'b11:
            begin
                if (skid_valid_reg)
                begin
                    head_next = skid_reg;
                    skid_next = push_data;
                end
                else
                begin
                    head_next = push_data;
                end
            end
            2'b01:
            begin
                head_next       = skid_reg;
                head_valid_next = skid_valid_reg;
                skid_valid_next = 1'b0;
            end
            2'b10:
            begin
                if (!head_valid_reg)
                begin
                    head_next       = push_data;
                    head_valid_next = 1'b1;
                end
                else
                begin
                    skid_next       = push_data;
                    skid_valid_next = 1'b1;
                end
            end
            default: head_next = head_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign can_push  = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

endmodule

`default_nettype wire

// ===== rtl/core/button_gesture_fsm_core.sv =====
// ----------------------------------------------------------------------------
// button_gesture_fsm_core
// eight-state button gesture machine with debounce and long-press timing
//
// input stream: one event code per request on s_tdata; every request gives
// exactly one result request on m_tdata (applied flag, prior and new state,
// effect code, timer duration for start-timer effects)
// configuration: cfg_valid/cfg_ready write of a timer duration, index 0
// debounce, 1 long press, 2 self-test arm window; other indexes are ignored;
// cfg_ready is always high
// output: each result is registered in the output buffer before it shows on m_tvalid
// throughput: one event per cycle while s_tready is high; the transition decode
// is combinational and the state register updates on each taken event
// stall: results queue in an output register and a skid slot, so one more
// event is taken while a result waits; s_tready drops once both are full
// reset: state returns to idle, timer registers to 20, 1000 and 5000 ms,
// pending results are dropped
// ----------------------------------------------------------------------------
`default_nettype none

module button_gesture_fsm_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [bgf_pkg::InDataW-1:0]      s_tdata,   // [2:0] event_kind
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [0] applied, [3:1] prior_state, [6:4] new_state, [8:7] effect_code,
    // [24:9] timer_value
    output logic [bgf_pkg::OutDataW-1:0]          m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bgf_pkg::CfgIndexW-1:0]    cfg_index,
    input  wire logic [bgf_pkg::TimerW-1:0]       cfg_data
);

    localparam int unsigned ResultW = $bits(bgf_pkg::result_t);

    bgf_pkg::timers_t timers;
    bgf_pkg::result_t step_result;
    bgf_pkg::result_t out_result;
    logic             accept;
    logic             can_push;

    assign cfg_ready = 1'b1;
    assign s_tready  = can_push;
    assign accept    = s_tvalid && can_push;

    bgf_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .timers   (timers)
    );

    bgf_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .event_kind (s_tdata[2:0]),
        .timers     (timers),
        .result     (step_result)
    );

    bgf_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (step_result),
        .can_push  (can_push),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {{(bgf_pkg::OutDataW - ResultW){1'b0}}, out_result};

endmodule

`default_nettype wire
